>>> design/voxel_face_cull_with_ao_top_assert.svh
// assertion macros used by the checker file
`ifndef VOXEL_FACE_CULL_WITH_AO_TOP_ASSERT_SVH
`define VOXEL_FACE_CULL_WITH_AO_TOP_ASSERT_SVH

// checked only outside reset
`define VFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked during reset as well
`define VFC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/vfc_pkg.sv
package vfc_pkg;

	localparam int NB_W      = 27;
	localparam int POS_W     = 4;
	localparam int COLOUR_W  = 24;
	localparam int DIR_W     = 3;
	localparam int AO_W      = 2;
	localparam int COUNT_W   = 17;
	localparam int NUM_DIRS  = 6;
	localparam int NUM_VERTS = 4;
	localparam int CENTRE_BIT = 13;
	localparam int FACE_VERTS = 4;

	localparam int NORMAL [NUM_DIRS][3] = '{
		'{ 1, 0, 0}, '{-1, 0, 0}, '{0, 1, 0}, '{0, -1, 0}, '{0, 0, 1}, '{0, 0, -1}
	};

	localparam int SIDES [NUM_DIRS][4][3] = '{
		'{'{0, -1, 0}, '{0, 0, 1},  '{0, 1, 0}, '{0, 0, -1}},
		'{'{0, -1, 0}, '{0, 0, -1}, '{0, 1, 0}, '{0, 0, 1}},
		'{'{0, 0, 1},  '{-1, 0, 0}, '{0, 0, -1}, '{1, 0, 0}},
		'{'{0, 0, -1}, '{-1, 0, 0}, '{0, 0, 1}, '{1, 0, 0}},
		'{'{0, -1, 0}, '{-1, 0, 0}, '{0, 1, 0}, '{1, 0, 0}},
		'{'{0, -1, 0}, '{1, 0, 0},  '{0, 1, 0}, '{-1, 0, 0}}
	};

	localparam int VPAIR [NUM_VERTS][2] = '{'{0, 1}, '{3, 0}, '{2, 3}, '{1, 2}};

	typedef logic [NUM_DIRS-1:0] dir_mask_t;

	typedef struct packed {
		logic [DIR_W-1:0]                dir;
		logic [NUM_VERTS-1:0][AO_W-1:0]  ao;
		dir_mask_t                       rest;
		logic                            last;
	} face_sel_t;

	function automatic int cell_index(input int x, input int y, input int z);
		return (x + 1) + (y + 1) * 3 + (z + 1) * 9;
	endfunction

	// faces whose neighbour is empty, none when the centre is empty
	function automatic dir_mask_t open_faces(input logic [NB_W-1:0] nb);
		dir_mask_t m;
		m = '0;
		for (int d = 0; d < NUM_DIRS; d++) begin
			m[d] = nb[CENTRE_BIT] &
				~nb[5'(cell_index(NORMAL[d][0], NORMAL[d][1], NORMAL[d][2]))];
		end
		return m;
	endfunction

	function automatic logic [NUM_VERTS-1:0][AO_W-1:0] face_ao(
		input logic [NB_W-1:0] nb,
		input int d
	);
		logic [NUM_VERTS-1:0][AO_W-1:0] r;
		logic s1;
		logic s2;
		logic c;
		int pa;
		int pb;
		r = '0;
		for (int v = 0; v < NUM_VERTS; v++) begin
			pa = VPAIR[v][0];
			pb = VPAIR[v][1];
			s1 = nb[5'(cell_index(NORMAL[d][0] + SIDES[d][pa][0],
				NORMAL[d][1] + SIDES[d][pa][1], NORMAL[d][2] + SIDES[d][pa][2]))];
			s2 = nb[5'(cell_index(NORMAL[d][0] + SIDES[d][pb][0],
				NORMAL[d][1] + SIDES[d][pb][1], NORMAL[d][2] + SIDES[d][pb][2]))];
			c = nb[5'(cell_index(
				NORMAL[d][0] + SIDES[d][pa][0] + SIDES[d][pb][0],
				NORMAL[d][1] + SIDES[d][pa][1] + SIDES[d][pb][1],
				NORMAL[d][2] + SIDES[d][pa][2] + SIDES[d][pb][2]))];
			if (s1 && s2) begin
				r[v] = '0;
			end else begin
				r[v] = 2'd3 - 2'(s1) - 2'(s2) - 2'(c);
			end
		end
		return r;
	endfunction

endpackage

>>> design/vfc_channel_if.sv
interface vfc_voxel_if;
	import vfc_pkg::*;

	logic                valid;
	logic                ready;
	logic [NB_W-1:0]     neighbourhood;
	logic [POS_W-1:0]    block_x;
	logic [POS_W-1:0]    block_y;
	logic [POS_W-1:0]    block_z;
	logic [COLOUR_W-1:0] colour_rgb;
	logic                first_block;

	modport source (
		output valid, neighbourhood, block_x, block_y, block_z, colour_rgb, first_block,
		input  ready
	);
	modport sink (
		input  valid, neighbourhood, block_x, block_y, block_z, colour_rgb, first_block,
		output ready
	);
endinterface

interface vfc_face_if;
	import vfc_pkg::*;

	logic                valid;
	logic                ready;
	logic [DIR_W-1:0]    face_dir;
	logic [POS_W-1:0]    face_x;
	logic [POS_W-1:0]    face_y;
	logic [POS_W-1:0]    face_z;
	logic [AO_W-1:0]     ao_v0;
	logic [AO_W-1:0]     ao_v1;
	logic [AO_W-1:0]     ao_v2;
	logic [AO_W-1:0]     ao_v3;
	logic [COUNT_W-1:0]  base_vertex;
	logic [COLOUR_W-1:0] face_colour;
	logic                last_face;

	modport source (
		output valid, face_dir, face_x, face_y, face_z, ao_v0, ao_v1, ao_v2, ao_v3,
			base_vertex, face_colour, last_face,
		input  ready
	);
	modport sink (
		input  valid, face_dir, face_x, face_y, face_z, ao_v0, ao_v1, ao_v2, ao_v3,
			base_vertex, face_colour, last_face,
		output ready
	);
endinterface

>>> design/vfc_face_sel.sv
module vfc_face_sel (
	input  vfc_pkg::dir_mask_t         mask,
	input  logic [vfc_pkg::NB_W-1:0]   nb,
	output vfc_pkg::face_sel_t         sel
);
	import vfc_pkg::*;

	logic [NUM_DIRS-1:0][NUM_VERTS-1:0][AO_W-1:0] ao_all;
	logic [DIR_W-1:0] dir;
	dir_mask_t        rest;

	always_comb begin
		for (int d = 0; d < NUM_DIRS; d++) begin
			ao_all[d] = face_ao(nb, d);
		end
	end

	// lowest pending direction first
	always_comb begin
		dir = '0;
		for (int d = NUM_DIRS - 1; d >= 0; d--) begin
			if (mask[d]) begin
				dir = DIR_W'(d);
			end
		end
		rest = mask;
		rest[dir] = 1'b0;
	end

	assign sel.dir  = dir;
	assign sel.ao   = ao_all[dir];
	assign sel.rest = rest;
	assign sel.last = (rest == '0);

endmodule

>>> design/voxel_face_cull_with_ao_top.sv
// Voxel face culling with ambient occlusion. A voxel item with a solid centre and k empty
// axis neighbours produces k face items in +X,-X,+Y,-Y,+Z,-Z order, one per cycle unless
// face.ready stalls the single output register, so it holds the working stage until its last
// face is issued; voxels with no visible face are absorbed on acceptance. The next voxel is
// taken in the cycle its predecessor's last face is issued. The first face passes through
// the working stage register and then the output register. base_vertex counts up by four per
// face, wraps at 2^17 and is cleared ahead of any voxel flagged first_block.
module voxel_face_cull_with_ao_top (
	input  logic             clk,
	input  logic             arst_n,
	vfc_voxel_if.sink        voxel,
	vfc_face_if.source       face
);
	import vfc_pkg::*;

	logic                valid_s1;
	dir_mask_t           mask_s1;
	logic [NB_W-1:0]     nb_s1;
	logic [POS_W-1:0]    x_s1;
	logic [POS_W-1:0]    y_s1;
	logic [POS_W-1:0]    z_s1;
	logic [COLOUR_W-1:0] colour_s1;
	logic                clr_s1;

	logic                valid_s2;
	logic [DIR_W-1:0]    dir_s2;
	logic [POS_W-1:0]    x_s2;
	logic [POS_W-1:0]    y_s2;
	logic [POS_W-1:0]    z_s2;
	logic [NUM_VERTS-1:0][AO_W-1:0] ao_s2;
	logic [COUNT_W-1:0]  base_s2;
	logic [COLOUR_W-1:0] colour_s2;
	logic                last_s2;

	logic [COUNT_W-1:0]  count_q;

	dir_mask_t           mask_in;
	face_sel_t           sel;
	logic                emit;
	logic                accept;
	logic [COUNT_W-1:0]  base;

	vfc_face_sel u_face_sel (
		.mask (mask_s1),
		.nb   (nb_s1),
		.sel  (sel)
	);

	always_comb begin
		mask_in     = open_faces(voxel.neighbourhood);
		emit        = valid_s1 && (!valid_s2 || face.ready);
		voxel.ready = !valid_s1 || (emit && sel.last);
		accept      = voxel.valid && voxel.ready;
		base        = clr_s1 ? '0 : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= (mask_in != '0);
			end else if (emit && sel.last) begin
				valid_s1 <= 1'b0;
			end
			if (emit) begin
				valid_s2 <= 1'b1;
			end else if (face.ready) begin
				valid_s2 <= 1'b0;
			end
			if (emit) begin
				count_q <= base + COUNT_W'(FACE_VERTS);
			end
			// voxel without faces still applies its counter clear
			if (accept && voxel.first_block && (mask_in == '0)) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mask_s1   <= mask_in;
			nb_s1     <= voxel.neighbourhood;
			x_s1      <= voxel.block_x;
			y_s1      <= voxel.block_y;
			z_s1      <= voxel.block_z;
			colour_s1 <= voxel.colour_rgb;
			clr_s1    <= voxel.first_block;
		end else if (emit) begin
			mask_s1 <= sel.rest;
			clr_s1  <= 1'b0;
		end
		if (emit) begin
			dir_s2    <= sel.dir;
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			z_s2      <= z_s1;
			ao_s2     <= sel.ao;
			base_s2   <= base;
			colour_s2 <= colour_s1;
			last_s2   <= sel.last;
		end
	end

	assign face.valid       = valid_s2;
	assign face.face_dir    = dir_s2;
	assign face.face_x      = x_s2;
	assign face.face_y      = y_s2;
	assign face.face_z      = z_s2;
	assign face.ao_v0       = ao_s2[0];
	assign face.ao_v1       = ao_s2[1];
	assign face.ao_v2       = ao_s2[2];
	assign face.ao_v3       = ao_s2[3];
	assign face.base_vertex = base_s2;
	assign face.face_colour = colour_s2;
	assign face.last_face   = last_s2;

endmodule

>>> design/vfc_checker.sv
`include "voxel_face_cull_with_ao_top_assert.svh"

module vfc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           face_valid,
	input logic                           face_ready,
	input logic [vfc_pkg::DIR_W-1:0]      face_dir,
	input logic [vfc_pkg::COUNT_W-1:0]    base_vertex,
	input logic                           last_face
);
	import vfc_pkg::*;

	`VFC_ASSERT_ALWAYS(a_idle_in_reset, !arst_n |-> !face_valid, "face item during reset")

	`VFC_ASSERT(a_dir_range, face_valid |-> face_dir <= 3'd5, "face direction out of range")

	// faces of one voxel leave back to back, counter and direction advancing
	`VFC_ASSERT(a_next_face, face_valid && face_ready && !last_face |=> face_valid && face_dir > $past(face_dir) && base_vertex == $past(base_vertex) + 17'd4, "broken face sequence")

	`VFC_ASSERT(a_hold, face_valid && !face_ready |=> face_valid && $stable(base_vertex) && $stable(face_dir), "stalled face item changed")

endmodule

bind voxel_face_cull_with_ao_top vfc_checker u_vfc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.face_valid  (face.valid),
	.face_ready  (face.ready),
	.face_dir    (face.face_dir),
	.base_vertex (face.base_vertex),
	.last_face   (face.last_face)
);
